### rtl/mlpic_pkg.sv
// shared constants, types and helpers for the perceptron inference block
package mlpic_pkg;

   localparam int MAX_LAYERS  = 4;
   localparam int MAX_NEURONS = 64;
   localparam int DATA_WIDTH  = 16;
   localparam int FRAC_BITS   = 8;

   localparam int LAYER_W  = $clog2(MAX_LAYERS);
   localparam int NEURON_W = $clog2(MAX_NEURONS);
   localparam int COUNT_W  = NEURON_W + 1;
   localparam int CMD_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 7;
   localparam int PROD_W   = 2 * DATA_WIDTH;
   localparam int ACC_W    = PROD_W + NEURON_W + 2;
   localparam int SHIFT_W  = ACC_W - FRAC_BITS;
   localparam int WADDR_W  = LAYER_W + 2 * NEURON_W;
   localparam int BADDR_W  = LAYER_W + NEURON_W;
   localparam int AADDR_W  = NEURON_W + 1;

   localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'((2 ** (DATA_WIDTH - 1)) - 1);
   localparam logic signed [SHIFT_W-1:0] SAT_LO = -SAT_HI - SHIFT_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_WEIGHT  = 2'd0,
      CMD_BIAS    = 2'd1,
      CMD_FEATURE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INPUT_WIDTH = 3'd0,
      CSR_LAYER_COUNT = 3'd1,
      CSR_LAYER0_SIZE = 3'd2,
      CSR_LAYER1_SIZE = 3'd3,
      CSR_LAYER2_SIZE = 3'd4,
      CSR_LAYER3_SIZE = 3'd5
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MAC   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   // neuron count register to 1..MAX_NEURONS
   function automatic logic [COUNT_W-1:0] clamp_size(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = v;
      if (v == '0) r = COUNT_W'(1);
      else if (v > COUNT_W'(MAX_NEURONS)) r = COUNT_W'(MAX_NEURONS);
      return r;
   endfunction

endpackage

### rtl/mlpic_if.sv
// request, response and csr channel interfaces
interface mlpic_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [mlpic_pkg::CMD_W-1:0]           command;
   logic [mlpic_pkg::LAYER_W-1:0]         layer_select;
   logic [mlpic_pkg::NEURON_W-1:0]        neuron_select;
   logic [mlpic_pkg::NEURON_W-1:0]        weight_select;
   logic signed [mlpic_pkg::DATA_WIDTH-1:0] value;
   logic                                  last_feature;
   modport source (output valid, command, layer_select, neuron_select, weight_select,
                   value, last_feature, input ready);
   modport sink (input valid, command, layer_select, neuron_select, weight_select,
                 value, last_feature, output ready);
endinterface

interface mlpic_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [mlpic_pkg::NEURON_W-1:0]        class_index;
   logic signed [mlpic_pkg::DATA_WIDTH-1:0] output_value;
   logic                                  is_regression;
   logic                                  saturated;
   modport source (output valid, class_index, output_value, is_regression, saturated,
                   input ready);
   modport sink (input valid, class_index, output_value, is_regression, saturated,
                 output ready);
endinterface

interface mlpic_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [mlpic_pkg::CSR_IDX_W-1:0]       index;
   logic [mlpic_pkg::CSR_DAT_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/mlp_inference_classifier.sv
// dense perceptron inference engine with weight, bias and activation memories
// a load item is written to its memory when accepted; a last feature starts inference, which
//   runs the mac state over each neuron's inputs and then drains the mac pipeline, neuron by neuron and layer by layer
// throughput: one multiply-accumulate per cycle, set by the single weight memory read port
// a new item is accepted only while idle; a waiting result does not block loads
// reset (synchronous, active high) restores the csr defaults, clears the feature count,
//   the feature valid bits and the response; weight and bias memories are not cleared
module mlp_inference_classifier (
   input  logic        clock,
   input  logic        reset,
   mlpic_req_if.sink   req_ch,
   mlpic_rsp_if.source rsp_ch,
   mlpic_csr_if.sink   csr_ch
);
   import mlpic_pkg::*;

   // memories
   logic [DATA_WIDTH-1:0] weight_mem [2**WADDR_W];
   logic [DATA_WIDTH-1:0] bias_mem   [2**BADDR_W];
   logic [DATA_WIDTH-1:0] act_mem    [2**AADDR_W];  // bank bit on top

   // csr registers
   logic [COUNT_W-1:0]   in_width_ff;
   logic [2:0]           layer_cnt_ff;
   logic [COUNT_W-1:0]   lsize_ff [MAX_LAYERS];

   // sequencer state
   state_type            state_ff, state_in;
   logic [LAYER_W-1:0]   layer_ff;
   logic [NEURON_W-1:0]  neuron_ff;
   logic [NEURON_W-1:0]  idx_ff;
   logic [COUNT_W-1:0]   feat_cnt_ff;
   logic [MAX_NEURONS-1:0] feat_vld_ff;

   // mac pipeline
   logic                 p1_ff, p2_ff, first1_ff, mask1_ff;
   logic [DATA_WIDTH-1:0] wrd_ff, ard_ff, brd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // per-inference results
   logic                 sat_ff;
   logic signed [DATA_WIDTH-1:0] best_val_ff;
   logic [NEURON_W-1:0]  best_idx_ff;

   // response register
   logic                 rsp_vld_ff;
   logic [NEURON_W-1:0]  rsp_class_ff;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff;
   logic                 rsp_reg_ff;
   logic                 rsp_sat_ff;

   // effective configuration
   logic [LAYER_W-1:0]   last_layer;
   logic [COUNT_W-1:0]   fan, cur_size;
   logic                 mac_last, neuron_last, is_out_layer;
   logic [COUNT_W-1:0]   out_size;

   always_comb begin
      if (layer_cnt_ff == 3'd0) last_layer = '0;
      else if (layer_cnt_ff > 3'(MAX_LAYERS)) last_layer = LAYER_W'(MAX_LAYERS - 1);
      else last_layer = LAYER_W'(layer_cnt_ff - 3'd1);
   end

   // layer 0 reads the feature vector, later layers the previous layer's outputs
   assign fan = (layer_ff == '0) ? clamp_size(in_width_ff)
                                 : clamp_size(lsize_ff[layer_ff - LAYER_W'(1)]);
   assign cur_size     = clamp_size(lsize_ff[layer_ff]);
   assign out_size     = clamp_size(lsize_ff[last_layer]);
   assign mac_last     = ({1'b0, idx_ff} == fan - COUNT_W'(1));
   assign neuron_last  = ({1'b0, neuron_ff} == cur_size - COUNT_W'(1));
   assign is_out_layer = (layer_ff == last_layer);

   // handshakes
   logic req_acc, csr_acc, is_feat, drain_done;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_acc = req_ch.valid & req_ch.ready;
   assign csr_acc = csr_ch.valid & csr_ch.ready;
   assign is_feat = req_acc & (req_ch.command == CMD_FEATURE);
   assign drain_done = (state_ff == ST_DRAIN) & ~p1_ff & ~p2_ff;

   // neuron output: shift, saturate, relu on hidden layers
   logic signed [SHIFT_W-1:0]    shifted;
   logic signed [DATA_WIDTH-1:0] sat_val, neu_val;
   logic                         clipped;
   always_comb begin
      shifted = acc_ff[ACC_W-1:FRAC_BITS];
      clipped = 1'b0;
      sat_val = shifted[DATA_WIDTH-1:0];
      if (shifted > SAT_HI) begin
         sat_val = SAT_HI[DATA_WIDTH-1:0];
         clipped = 1'b1;
      end else if (shifted < SAT_LO) begin
         sat_val = SAT_LO[DATA_WIDTH-1:0];
         clipped = 1'b1;
      end
      neu_val = sat_val;
      if (!is_out_layer && sat_val[DATA_WIDTH-1]) neu_val = '0;
   end

   // activation write port: features while idle, neuron results at drain end
   logic                 act_we;
   logic [AADDR_W-1:0]   act_wa;
   logic [DATA_WIDTH-1:0] act_wd;
   always_comb begin
      act_we = 1'b0;
      act_wa = {1'b0, feat_cnt_ff[NEURON_W-1:0]};
      act_wd = req_ch.value;
      if (is_feat && !feat_cnt_ff[NEURON_W]) begin
         act_we = 1'b1;
      end else if (drain_done) begin
         act_we = 1'b1;
         act_wa = {~layer_ff[0], neuron_ff};
         act_wd = neu_val;
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (req_acc && req_ch.command == CMD_WEIGHT)
         weight_mem[{req_ch.layer_select, req_ch.neuron_select, req_ch.weight_select}]
            <= req_ch.value;
      wrd_ff <= weight_mem[{layer_ff, neuron_ff, idx_ff}];
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_ch.command == CMD_BIAS)
         bias_mem[{req_ch.layer_select, req_ch.neuron_select}] <= req_ch.value;
      brd_ff <= bias_mem[{layer_ff, neuron_ff}];
   end

   always_ff @(posedge clock) begin
      if (act_we) act_mem[act_wa] <= act_wd;
      ard_ff <= act_mem[{layer_ff[0], idx_ff}];
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff  <= COUNT_W'(64);
         layer_cnt_ff <= 3'd2;
         lsize_ff[0]  <= COUNT_W'(16);
         lsize_ff[1]  <= COUNT_W'(10);
         lsize_ff[2]  <= COUNT_W'(1);
         lsize_ff[3]  <= COUNT_W'(1);
      end else if (csr_acc) begin
         case (csr_ch.index)
            CSR_INPUT_WIDTH: in_width_ff  <= csr_ch.data;
            CSR_LAYER_COUNT: layer_cnt_ff <= csr_ch.data[2:0];
            CSR_LAYER0_SIZE: lsize_ff[0]  <= csr_ch.data;
            CSR_LAYER1_SIZE: lsize_ff[1]  <= csr_ch.data;
            CSR_LAYER2_SIZE: lsize_ff[2]  <= csr_ch.data;
            CSR_LAYER3_SIZE: lsize_ff[3]  <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (is_feat && req_ch.last_feature) state_in = ST_MAC;
         ST_MAC:   if (mac_last) state_in = ST_DRAIN;
         ST_DRAIN: if (drain_done) state_in = (neuron_last && is_out_layer) ? ST_OUT : ST_MAC;
         ST_OUT:   if (!rsp_vld_ff || rsp_ch.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer and pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         layer_ff    <= '0;
         neuron_ff   <= '0;
         idx_ff      <= '0;
         feat_cnt_ff <= '0;
         feat_vld_ff <= '0;
         p1_ff       <= 1'b0;
         p2_ff       <= 1'b0;
         first1_ff   <= 1'b0;
         sat_ff      <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         p1_ff     <= (state_ff == ST_MAC);
         first1_ff <= (state_ff == ST_MAC) && (idx_ff == '0);
         p2_ff     <= p1_ff;
         // result goes out from the output state, leaves when taken
         if (state_ff == ST_OUT && (!rsp_vld_ff || rsp_ch.ready)) rsp_vld_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_vld_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (is_feat) begin
                  if (!feat_cnt_ff[NEURON_W]) begin
                     feat_vld_ff[feat_cnt_ff[NEURON_W-1:0]] <= 1'b1;
                     feat_cnt_ff <= feat_cnt_ff + COUNT_W'(1);
                  end
                  if (req_ch.last_feature) begin
                     layer_ff  <= '0;
                     neuron_ff <= '0;
                     idx_ff    <= '0;
                     sat_ff    <= 1'b0;
                  end
               end
            end
            ST_MAC: begin
               idx_ff <= mac_last ? '0 : idx_ff + NEURON_W'(1);
            end
            ST_DRAIN: begin
               if (drain_done) begin
                  if (clipped) sat_ff <= 1'b1;
                  if (neuron_last) begin
                     neuron_ff <= '0;
                     if (!is_out_layer) layer_ff <= layer_ff + LAYER_W'(1);
                  end else begin
                     neuron_ff <= neuron_ff + NEURON_W'(1);
                  end
               end
            end
            ST_OUT: begin
               if (!rsp_vld_ff || rsp_ch.ready) begin
                  feat_cnt_ff <= '0;
                  feat_vld_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // mac datapath: read, multiply, accumulate
   always_ff @(posedge clock) begin
      mask1_ff <= (layer_ff != '0) || feat_vld_ff[idx_ff];
      prod_ff  <= signed'(wrd_ff) * (mask1_ff ? signed'(ard_ff) : signed'(DATA_WIDTH'(0)));
      if (p1_ff && first1_ff)
         acc_ff <= {{(ACC_W-DATA_WIDTH-FRAC_BITS){brd_ff[DATA_WIDTH-1]}}, brd_ff,
                    {FRAC_BITS{1'b0}}};
      else if (p2_ff)
         acc_ff <= acc_ff + ACC_W'(prod_ff);
   end

   // running argmax over the output layer, first strict maximum wins
   always_ff @(posedge clock) begin
      if (drain_done && is_out_layer) begin
         if (neuron_ff == '0 || neu_val > best_val_ff) begin
            best_val_ff <= neu_val;
            best_idx_ff <= neuron_ff;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_vld_ff || rsp_ch.ready)) begin
         rsp_class_ff <= best_idx_ff;
         rsp_value_ff <= best_val_ff;
         rsp_reg_ff   <= (out_size == COUNT_W'(1));
         rsp_sat_ff   <= sat_ff;
      end
   end

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.class_index   = rsp_class_ff;
   assign rsp_ch.output_value  = rsp_value_ff;
   assign rsp_ch.is_regression = rsp_reg_ff;
   assign rsp_ch.saturated     = rsp_sat_ff;

endmodule

### rtl/mlpic_checker.sv
// port-level checker for the inference block and its bind
module mlpic_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [mlpic_pkg::CMD_W-1:0] req_command,
   input logic                       req_last,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [mlpic_pkg::NEURON_W-1:0] rsp_class,
   input logic [mlpic_pkg::DATA_WIDTH-1:0] rsp_value,
   input logic                       rsp_regression
);
   import mlpic_pkg::*;

   // a last feature starts inference, so the input side goes busy
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_FEATURE && req_last) |=> !req_ready)
      else $error("input ready after last feature");

   // a new result only appears after a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without inference");

   // regression results carry class zero
   a_regression_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_regression) |-> (rsp_class == '0))
      else $error("regression result with nonzero class");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
      else $error("stalled result changed");

endmodule

bind mlp_inference_classifier mlpic_checker u_mlpic_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_command    (req_ch.command),
   .req_last       (req_ch.last_feature),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_class      (rsp_ch.class_index),
   .rsp_value      (rsp_ch.output_value),
   .rsp_regression (rsp_ch.is_regression)
);

### verif/testbench.sv
// self-checking testbench for the perceptron inference block
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mlpic_pkg::*;

   localparam int  NEURONS    = MAX_NEURONS;
   localparam int  DRAIN_WAIT = 40;
   localparam longint CYCLE_LIMIT = 4000000;
   localparam int  ITEM_TARGET = 1300;

   // one request item as it crosses the input channel
   typedef struct {
      cmd_type                 cmd;
      logic [LAYER_W-1:0]      layer;
      logic [NEURON_W-1:0]     neuron;
      logic [NEURON_W-1:0]     position;
      logic signed [DATA_WIDTH-1:0] value;
      logic                    last;
   } req_item_type;

   // one classification or regression result
   typedef struct {
      logic [NEURON_W-1:0]     class_index;
      logic signed [DATA_WIDTH-1:0] output_value;
      logic                    is_regression;
      logic                    saturated;
   } rsp_item_type;

   // golden copy of the network and the queue of predicted results
   class mlp_scoreboard_type;
      logic signed [DATA_WIDTH-1:0] weights [MAX_LAYERS*NEURONS*NEURONS];
      logic signed [DATA_WIDTH-1:0] biases  [MAX_LAYERS*NEURONS];
      bit      weight_set [MAX_LAYERS*NEURONS*NEURONS];
      bit      bias_set   [MAX_LAYERS*NEURONS];
      longint  features [NEURONS];
      int      feature_count;
      logic [CSR_DAT_W-1:0] regs [6];
      rsp_item_type predicted [$];
      int      errors;

      function new();
         regs[CSR_INPUT_WIDTH] = 7'd64;
         regs[CSR_LAYER_COUNT] = 7'd2;
         regs[CSR_LAYER0_SIZE] = 7'd16;
         regs[CSR_LAYER1_SIZE] = 7'd10;
         regs[CSR_LAYER2_SIZE] = 7'd1;
         regs[CSR_LAYER3_SIZE] = 7'd1;
         foreach (weight_set[i]) weight_set[i] = 0;
         foreach (bias_set[i]) bias_set[i] = 0;
         foreach (features[i]) features[i] = 0;
         feature_count = 0;
         errors = 0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [CSR_DAT_W-1:0] data);
         if (idx == CSR_LAYER_COUNT) regs[idx] = {4'b0, data[2:0]};
         else regs[idx] = data;
      endfunction

      function int neuron_count(int v);
         if (v == 0) return 1;
         if (v > NEURONS) return NEURONS;
         return v;
      endfunction

      function int layers_active();
         int v;
         v = regs[CSR_LAYER_COUNT];
         if (v == 0) return 1;
         if (v > MAX_LAYERS) return MAX_LAYERS;
         return v;
      endfunction

      function int layer_size(int l);
         return neuron_count(regs[CSR_LAYER0_SIZE + l]);
      endfunction

      function int layer_fan(int l);
         if (l == 0) return neuron_count(regs[CSR_INPUT_WIDTH]);
         return layer_size(l - 1);
      endfunction

      function int pending();
         return predicted.size();
      endfunction

      // forward pass over all active layers
      function void infer();
         longint    src [NEURONS];
         longint    dst [NEURONS];
         longint    acc;
         longint    v;
         int        nl, sz, fan, best;
         bit        clipped;
         rsp_item_type r;
         nl = layers_active();
         src = features;
         sz = 1;
         clipped = 0;
         for (int l = 0; l < nl; l++) begin
            sz = layer_size(l);
            fan = layer_fan(l);
            foreach (dst[i]) dst[i] = 0;
            for (int n = 0; n < sz; n++) begin
               acc = longint'(biases[l*NEURONS + n]) <<< FRAC_BITS;
               for (int i = 0; i < fan; i++)
                  acc += longint'(weights[(l*NEURONS + n)*NEURONS + i]) * src[i];
               v = acc >>> FRAC_BITS;
               if (v > 32767) begin v = 32767; clipped = 1; end
               if (v < -32768) begin v = -32768; clipped = 1; end
               // relu on hidden layers only
               if (l + 1 < nl && v < 0) v = 0;
               dst[n] = v;
            end
            src = dst;
         end
         best = 0;
         for (int n = 1; n < sz; n++)
            if (src[n] > src[best]) best = n;
         r.class_index   = best[NEURON_W-1:0];
         r.output_value  = src[best][DATA_WIDTH-1:0];
         r.is_regression = (sz == 1);
         r.saturated     = clipped;
         predicted = {predicted, r};
         foreach (features[i]) features[i] = 0;
         feature_count = 0;
      endfunction

      function void note_item(req_item_type it);
         int idx;
         case (it.cmd)
            CMD_WEIGHT: begin
               idx = (int'(it.layer)*NEURONS + int'(it.neuron))*NEURONS + int'(it.position);
               weights[idx] = it.value;
               weight_set[idx] = 1;
            end
            CMD_BIAS: begin
               idx = int'(it.layer)*NEURONS + int'(it.neuron);
               biases[idx] = it.value;
               bias_set[idx] = 1;
            end
            CMD_FEATURE: begin
               if (feature_count < NEURONS) begin
                  features[feature_count] = longint'(it.value);
                  feature_count++;
               end
               if (it.last) infer();
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (predicted.size() == 0) begin
            $display("%0t: unexpected result class %0d value %0d", $time,
                     got.class_index, got.output_value);
            errors++;
            return;
         end
         want = predicted.pop_front();
         if (got.class_index !== want.class_index) begin
            $display("%0t: class_index expected %0d actual %0d", $time,
                     want.class_index, got.class_index);
            errors++;
         end
         if (got.output_value !== want.output_value) begin
            $display("%0t: output_value expected %0d actual %0d", $time,
                     want.output_value, got.output_value);
            errors++;
         end
         if (got.is_regression !== want.is_regression) begin
            $display("%0t: is_regression expected %0b actual %0b", $time,
                     want.is_regression, got.is_regression);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $display("%0t: saturated expected %0b actual %0b", $time,
                     want.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   mlpic_req_if req_bus ();
   mlpic_rsp_if rsp_bus ();
   mlpic_csr_if csr_bus ();

   mlp_inference_classifier i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   mlp_scoreboard_type sb;
   longint cycles;
   int     rsp_stall;
   int     item_count;
   bit     no_gaps;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: accept at the rising edge, draw a new stall per item
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_item_type r;
         r.class_index   = rsp_bus.class_index;
         r.output_value  = rsp_bus.output_value;
         r.is_regression = rsp_bus.is_regression;
         r.saturated     = rsp_bus.saturated;
         sb.check_result(r);
         rsp_stall = no_gaps ? 0 : $urandom_range(0, 7);
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready = (rsp_stall == 0);
      if (rsp_stall > 0) rsp_stall--;
   end

   function int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 7);
   endfunction

   // value mix: mostly small so that saturation stays occasional
   function logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return DATA_WIDTH'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'sh7fff;
               1: return 16'sh8000;
               2: return 16'sh0000;
               default: return 16'sh0100;
            endcase
         end
         default: return DATA_WIDTH'($urandom_range(0, 1023)) - 16'sd512;
      endcase
   endfunction

   // drives one item; starts and ends at a falling edge
   task automatic send_item(req_item_type it, int gap);
      if (gap > 0) begin
         req_bus.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_bus.command       = it.cmd;
      req_bus.layer_select  = it.layer;
      req_bus.neuron_select = it.neuron;
      req_bus.weight_select = it.position;
      req_bus.value         = it.value;
      req_bus.last_feature  = it.last;
      req_bus.valid         = 1;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
      sb.note_item(it);
      item_count++;
      @(negedge clock);
   endtask

   task automatic send_load(cmd_type cmd, int l, int n, int p,
                            logic signed [DATA_WIDTH-1:0] v, bit last, int gap);
      req_item_type it;
      it.cmd = cmd;
      it.layer = LAYER_W'(l);
      it.neuron = NEURON_W'(n);
      it.position = NEURON_W'(p);
      it.value = v;
      it.last = last;
      send_item(it, gap);
   endtask

   task automatic send_feature(logic signed [DATA_WIDTH-1:0] v, bit last);
      send_load(CMD_FEATURE, $urandom_range(0, 3), $urandom_range(0, 63),
                $urandom_range(0, 63), v, last, draw_gap());
   endtask

   task automatic csr_write(csr_idx_type idx, logic [CSR_DAT_W-1:0] data);
      repeat (draw_gap()) @(negedge clock);
      csr_bus.index = idx;
      csr_bus.data  = data;
      csr_bus.valid = 1;
      forever begin
         @(posedge clock);
         if (csr_bus.ready) break;
      end
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_bus.valid = 0;
   endtask

   // hold the sender until every predicted result is back, then let the engine settle
   task automatic drain();
      req_bus.valid = 0;
      while (sb.pending() > 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic configure(int iw, int lc, int s0, int s1, int s2, int s3);
      csr_write(CSR_INPUT_WIDTH, CSR_DAT_W'(iw));
      csr_write(CSR_LAYER_COUNT, CSR_DAT_W'(lc));
      csr_write(CSR_LAYER0_SIZE, CSR_DAT_W'(s0));
      csr_write(CSR_LAYER1_SIZE, CSR_DAT_W'(s1));
      csr_write(CSR_LAYER2_SIZE, CSR_DAT_W'(s2));
      csr_write(CSR_LAYER3_SIZE, CSR_DAT_W'(s3));
   endtask

   // writes every weight and bias the current setting reads and that is still unset
   task automatic fill_network();
      for (int l = 0; l < sb.layers_active(); l++)
         for (int n = 0; n < sb.layer_size(l); n++) begin
            if (!sb.bias_set[l*NEURONS + n])
               send_load(CMD_BIAS, l, n, 0, pick_value(), 0, draw_gap());
            for (int i = 0; i < sb.layer_fan(l); i++)
               if (!sb.weight_set[(l*NEURONS + n)*NEURONS + i])
                  send_load(CMD_WEIGHT, l, n, i, pick_value(), 0, draw_gap());
         end
   endtask

   // one vector with random loads, noise and odd lengths mixed in
   task automatic random_vector();
      int len;
      int fan;
      fan = sb.layer_fan(0);
      case ($urandom_range(0, 9))
         0: len = $urandom_range(1, fan);
         1: len = fan + $urandom_range(1, 8);
         default: len = fan;
      endcase
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(0, 19))
            0, 1: begin
               send_load(CMD_WEIGHT, $urandom_range(0, 3), $urandom_range(0, 63),
                         $urandom_range(0, 63), pick_value(), 1'($urandom_range(0, 1)),
                         draw_gap());
            end
            2: begin
               send_load(CMD_BIAS, $urandom_range(0, 3), $urandom_range(0, 63),
                         $urandom_range(0, 63), pick_value(), 1'($urandom_range(0, 1)),
                         draw_gap());
            end
            3: send_load(CMD_NONE, $urandom_range(0, 3), $urandom_range(0, 63),
                         $urandom_range(0, 63), DATA_WIDTH'($urandom),
                         1'($urandom_range(0, 1)), draw_gap());
            default: ;
         endcase
         send_feature(pick_value(), k == len - 1);
      end
   endtask

   // register value: mostly small, sometimes zero or a little above the usual range
   function int pick_reg(int hi_small);
      case ($urandom_range(0, 15))
         0: return 0;
         1: return $urandom_range(hi_small + 1, 2 * hi_small);
         default: return $urandom_range(1, hi_small);
      endcase
   endfunction

   initial begin
      sb = new();
      cycles = 0;
      rsp_stall = 0;
      item_count = 0;
      no_gaps = 0;
      reset = 1;
      req_bus.valid = 0;
      req_bus.command = CMD_NONE;
      req_bus.layer_select = '0;
      req_bus.neuron_select = '0;
      req_bus.weight_select = '0;
      req_bus.value = '0;
      req_bus.last_feature = 0;
      rsp_bus.ready = 1;
      csr_bus.valid = 0;
      csr_bus.index = CSR_INPUT_WIDTH;
      csr_bus.data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;
      repeat (DRAIN_WAIT) @(negedge clock);

      // directed: two inputs, 3 hidden, 2 outputs
      configure(2, 2, 3, 2, 1, 1);
      fill_network();
      // equal outputs: first maximum wins
      for (int n = 0; n < 2; n++) begin
         send_load(CMD_BIAS, 1, n, 0, 16'sh7fff, 0, draw_gap());
         for (int i = 0; i < 3; i++) send_load(CMD_WEIGHT, 1, n, i, 16'sh0000, 0, draw_gap());
      end
      send_feature(16'sh8000, 0);
      send_feature(16'sh7fff, 1);
      // ignored command and a last flag on a weight write
      send_load(CMD_NONE, 3, 63, 63, 16'sh7fff, 1, draw_gap());
      send_load(CMD_WEIGHT, 3, 63, 63, 16'sh8000, 1, draw_gap());
      // missing features read as zero
      send_feature(16'sh0100, 1);
      // heavy weights drive the hidden layer into clipping
      for (int i = 0; i < 2; i++) send_load(CMD_WEIGHT, 0, 0, i, 16'sh7fff, 0, draw_gap());
      send_load(CMD_WEIGHT, 1, 1, 0, 16'sh8000, 0, draw_gap());
      send_feature(16'sh7fff, 0);
      send_feature(16'sh7fff, 1);
      // extra features beyond the input width and beyond the store
      for (int k = 0; k < 70; k++) send_feature(pick_value(), k == 69);
      drain();

      // four layers, 64 inputs and 64 classes, clamped from out-of-range register values
      configure(127, 7, 1, 127, 1, 127);
      fill_network();
      no_gaps = 1;
      random_vector();
      no_gaps = 0;
      random_vector();
      drain();

      // smallest network from all-zero registers: single regression neuron
      configure(0, 0, 0, 0, 0, 0);
      fill_network();
      for (int k = 0; k < 6; k++) random_vector();
      drain();

      // random phases
      while (item_count < ITEM_TARGET) begin
         configure(pick_reg(8), $urandom_range(0, 7), pick_reg(8), pick_reg(8),
                   pick_reg(8), pick_reg(8));
         fill_network();
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int v = $urandom_range(3, 8); v > 0; v--) random_vector();
         drain();
         no_gaps = 0;
      end

      drain();
      if (sb.pending() > 0) sb.errors++;
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
